/* rtl/wst_pkg.sv */
`default_nettype none

package wst_pkg;

  // Field widths of the request and result channels.
  localparam int OP_W     = 1;
  localparam int IDX_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int VALUE_W  = 16;
  localparam int ROLL_W   = 22;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 22;

  // Default sizing of the tree.
  localparam int LEAVES_DEF      = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF  = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_DRAW  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DRAWN   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    chosen_index;
    logic [VALUE_W-1:0]  chosen_value;
    logic [TOTAL_W-1:0]  total_weight;
  } wst_result_t;

endpackage

`default_nettype wire

/* rtl/wst_ram.sv */
`default_nettype none

module wst_ram #(
  parameter int DEPTH  = wst_pkg::LEAVES_DEF,
  parameter int WIDTH  = wst_pkg::VALUE_BITS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    // Read data holds while no new read is issued.
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/wst_walker.sv */
`default_nettype none

module wst_walker #(
  parameter int LEAVES      = wst_pkg::LEAVES_DEF,
  parameter int WEIGHT_BITS = wst_pkg::WEIGHT_BITS_DEF,
  parameter int VALUE_BITS  = wst_pkg::VALUE_BITS_DEF,
  parameter int TREE_D      = $clog2(LEAVES),
  parameter int NODE_AW     = TREE_D + 1,
  parameter int SUM_W       = WEIGHT_BITS + TREE_D
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wst_pkg::OP_W-1:0]     in_operation,
  input  logic [wst_pkg::IDX_W-1:0]    in_leaf_index,
  input  logic [wst_pkg::WEIGHT_W-1:0] in_item_weight,
  input  logic [wst_pkg::VALUE_W-1:0]  in_item_value,
  input  logic [wst_pkg::ROLL_W-1:0]   in_roll,
  output logic                         node_wr_en,
  output logic [NODE_AW-1:0]           node_wr_addr,
  output logic [SUM_W-1:0]             node_wr_data,
  output logic                         node_rd_en,
  output logic [NODE_AW-1:0]           node_rd_addr,
  input  logic [SUM_W-1:0]             node_rd_data,
  output logic                         val_wr_en,
  output logic [TREE_D-1:0]            val_wr_addr,
  output logic [VALUE_BITS-1:0]        val_wr_data,
  output logic                         val_rd_en,
  output logic [TREE_D-1:0]            val_rd_addr,
  input  logic [VALUE_BITS-1:0]        val_rd_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output wst_pkg::wst_result_t         res
);

  import wst_pkg::*;

  localparam int NODES = (2 ** NODE_AW) - 1;
  localparam int CMP_W = (SUM_W > ROLL_W) ? SUM_W : ROLL_W;
  localparam logic [NODE_AW-1:0] FIRST_LEAF = NODE_AW'((2 ** TREE_D) - 1);
  localparam logic [NODE_AW-1:0] LAST_NODE  = NODE_AW'(NODES - 1);
  localparam logic [NODE_AW-1:0] ROOT_LEFT  = NODE_AW'(1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_UP    = 5'b00100,
    S_DOWN  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [NODE_AW-1:0]   clr_r, clr_nxt;
  logic [SUM_W-1:0]     total_r, total_nxt;
  logic [NODE_AW-1:0]   node_r, node_nxt;
  logic [SUM_W-1:0]     acc_r, acc_nxt;
  logic [SUM_W-1:0]     roll_r, roll_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [IDX_W-1:0]     index_r, index_nxt;
  logic                 val_sel_r, val_sel_nxt;

  logic                 leaf_ok;
  logic [NODE_AW-1:0]   leaf_node;
  logic [SUM_W-1:0]     weight_ext;
  logic                 refuse;
  logic [NODE_AW-1:0]   parent;
  logic [SUM_W-1:0]     up_sum;
  logic [NODE_AW-1:0]   left_child;
  logic                 go_left;
  logic [NODE_AW-1:0]   down_node;
  logic [SUM_W-1:0]     down_roll;
  logic                 at_leaf;
  logic [TREE_D-1:0]    down_leaf;
  logic                 leaf_in;

  function automatic logic [NODE_AW-1:0] sibling(input logic [NODE_AW-1:0] n);
    return n[0] ? n + 1'b1 : n - 1'b1;
  endfunction

  assign leaf_ok    = 32'(in_leaf_index) < 32'(LEAVES);
  assign leaf_node  = FIRST_LEAF + NODE_AW'(in_leaf_index);
  assign weight_ext = SUM_W'(WEIGHT_BITS'(in_item_weight));
  assign refuse     = (total_r == '0) || (CMP_W'(in_roll) >= CMP_W'(total_r));

  assign parent = (node_r - 1'b1) >> 1;
  assign up_sum = acc_r + node_rd_data;

  assign left_child = {node_r[NODE_AW-2:0], 1'b1};
  assign go_left    = roll_r < node_rd_data;
  assign down_node  = go_left ? left_child : left_child + 1'b1;
  assign down_roll  = go_left ? roll_r : roll_r - node_rd_data;
  assign at_leaf    = down_node >= FIRST_LEAF;
  assign down_leaf  = TREE_D'(down_node + 1'b1);
  assign leaf_in    = 32'(down_leaf) < 32'(LEAVES);

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    total_nxt   = total_r;
    node_nxt    = node_r;
    acc_nxt     = acc_r;
    roll_nxt    = roll_r;
    status_nxt  = status_r;
    index_nxt   = index_r;
    val_sel_nxt = val_sel_r;

    node_wr_en   = 1'b0;
    node_wr_addr = node_r;
    node_wr_data = '0;
    node_rd_en   = 1'b0;
    node_rd_addr = '0;
    val_wr_en    = 1'b0;
    val_wr_addr  = TREE_D'(in_leaf_index);
    val_wr_data  = VALUE_BITS'(in_item_value);
    val_rd_en    = 1'b0;
    val_rd_addr  = down_leaf;

    case (state_r)
      S_CLEAR: begin
        node_wr_en   = 1'b1;
        node_wr_addr = clr_r;
        clr_nxt      = clr_r + 1'b1;
        if (clr_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          index_nxt   = '0;
          val_sel_nxt = 1'b0;
          if (in_operation == OP_WRITE) begin
            status_nxt = ST_WRITTEN;
            if (leaf_ok) begin
              node_wr_en   = 1'b1;
              node_wr_addr = leaf_node;
              node_wr_data = weight_ext;
              val_wr_en    = 1'b1;
              node_rd_en   = 1'b1;
              node_rd_addr = sibling(leaf_node);
              node_nxt     = leaf_node;
              acc_nxt      = weight_ext;
              state_nxt    = S_UP;
            end else begin
              state_nxt = S_RESP;
            end
          end else if (refuse) begin
            status_nxt = ST_REFUSED;
            state_nxt  = S_RESP;
          end else begin
            status_nxt   = ST_DRAWN;
            node_nxt     = '0;
            roll_nxt     = SUM_W'(in_roll);
            node_rd_en   = 1'b1;
            node_rd_addr = ROOT_LEFT;
            state_nxt    = S_DOWN;
          end
        end
      end
      S_UP: begin
        // Parent gets the running sum plus the sibling read last cycle.
        node_wr_en   = 1'b1;
        node_wr_addr = parent;
        node_wr_data = up_sum;
        acc_nxt      = up_sum;
        node_nxt     = parent;
        if (parent == '0) begin
          total_nxt = up_sum;
          state_nxt = S_RESP;
        end else begin
          node_rd_en   = 1'b1;
          node_rd_addr = sibling(parent);
        end
      end
      S_DOWN: begin
        node_nxt = down_node;
        roll_nxt = down_roll;
        if (at_leaf) begin
          index_nxt   = leaf_in ? IDX_W'(down_leaf) : '0;
          val_sel_nxt = leaf_in;
          val_rd_en   = leaf_in;
          state_nxt   = S_RESP;
        end else begin
          node_rd_en   = 1'b1;
          node_rd_addr = {down_node[NODE_AW-2:0], 1'b1};
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    acc_r     <= acc_nxt;
    roll_r    <= roll_nxt;
    status_r  <= status_nxt;
    index_r   <= index_nxt;
    val_sel_r <= val_sel_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  assign res.status       = status_r;
  assign res.chosen_index = index_r;
  assign res.chosen_value = val_sel_r ? VALUE_W'(val_rd_data) : '0;
  assign res.total_weight = TOTAL_W'(total_r);

  // The path update never reads the node it writes, so no forwarding is needed.
  a_no_same_node: assert property (@(posedge clk) disable iff (!rst_n)
    node_wr_en && node_rd_en |-> node_wr_addr != node_rd_addr)
    else $error("node memory read and write hit the same entry");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed before it was taken");

  a_draw_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status == ST_DRAWN) |-> total_r != '0)
    else $error("sample drawn from an empty tree");

  a_no_write_late: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DOWN) || (state_r == S_RESP) |-> !node_wr_en && !val_wr_en)
    else $error("memory written during a descent or a pending result");

endmodule

`default_nettype wire

/* rtl/weighted_sum_tree_sampler.sv */
`default_nettype none
// A write or an accepted draw walks all D = clog2(LEAVES) tree levels before its result
// is shown; a refused draw or ignored write goes straight to its result.
// A new request is taken only once the last result has been handed to the output
// register, since the walk visits the single node memory once per tree level.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the 2^(D+1)-1 node sums,
// one per cycle, with in_stall high. Leaf values are not cleared.

module weighted_sum_tree_sampler #(
  parameter int LEAVES      = wst_pkg::LEAVES_DEF,
  parameter int WEIGHT_BITS = wst_pkg::WEIGHT_BITS_DEF,
  parameter int VALUE_BITS  = wst_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wst_pkg::OP_W-1:0]      in_operation,
  input  logic [wst_pkg::IDX_W-1:0]     in_leaf_index,
  input  logic [wst_pkg::WEIGHT_W-1:0]  in_item_weight,
  input  logic [wst_pkg::VALUE_W-1:0]   in_item_value,
  input  logic [wst_pkg::ROLL_W-1:0]    in_roll,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wst_pkg::STATUS_W-1:0]  out_status,
  output logic [wst_pkg::IDX_W-1:0]     out_chosen_index,
  output logic [wst_pkg::VALUE_W-1:0]   out_chosen_value,
  output logic [wst_pkg::TOTAL_W-1:0]   out_total_weight
);

  import wst_pkg::*;

  // The tree is stored heap style: node 0 is the root, the children of node n are
  // 2n+1 and 2n+2, and the leaves occupy the last 2^D entries.
  localparam int TREE_D  = $clog2(LEAVES);
  localparam int NODE_AW = TREE_D + 1;
  localparam int SUM_W   = WEIGHT_BITS + TREE_D;
  localparam int NODES   = (2 ** NODE_AW) - 1;

  logic                  walker_ready;
  logic                  node_wr_en;
  logic [NODE_AW-1:0]    node_wr_addr;
  logic [SUM_W-1:0]      node_wr_data;
  logic                  node_rd_en;
  logic [NODE_AW-1:0]    node_rd_addr;
  logic [SUM_W-1:0]      node_rd_data;
  logic                  val_wr_en;
  logic [TREE_D-1:0]     val_wr_addr;
  logic [VALUE_BITS-1:0] val_wr_data;
  logic                  val_rd_en;
  logic [TREE_D-1:0]     val_rd_addr;
  logic [VALUE_BITS-1:0] val_rd_data;
  logic                  res_valid;
  logic                  res_ready;
  wst_result_t           res;

  logic                  out_valid_r, out_valid_nxt;
  wst_result_t           out_res_r;

  // The walker sequences both kinds of request. A write stores the leaf weight and
  // then climbs to the root, reading one sibling per level and writing the parent sum.
  // A draw descends from the root, reading one left-child sum per level.
  wst_walker #(
    .LEAVES      (LEAVES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (walker_ready),
    .in_operation   (in_operation),
    .in_leaf_index  (in_leaf_index),
    .in_item_weight (in_item_weight),
    .in_item_value  (in_item_value),
    .in_roll        (in_roll),
    .node_wr_en     (node_wr_en),
    .node_wr_addr   (node_wr_addr),
    .node_wr_data   (node_wr_data),
    .node_rd_en     (node_rd_en),
    .node_rd_addr   (node_rd_addr),
    .node_rd_data   (node_rd_data),
    .val_wr_en      (val_wr_en),
    .val_wr_addr    (val_wr_addr),
    .val_wr_data    (val_wr_data),
    .val_rd_en      (val_rd_en),
    .val_rd_addr    (val_rd_addr),
    .val_rd_data    (val_rd_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // Node sums: one write port and one registered read port.
  wst_ram #(
    .DEPTH  (NODES),
    .WIDTH  (SUM_W),
    .ADDR_W (NODE_AW)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (node_wr_en),
    .wr_addr (node_wr_addr),
    .wr_data (node_wr_data),
    .rd_en   (node_rd_en),
    .rd_addr (node_rd_addr),
    .rd_data (node_rd_data)
  );

  // Leaf values. Only leaves that carry weight can be drawn, and those have been
  // written, so this memory needs no clearing.
  wst_ram #(
    .DEPTH  (LEAVES),
    .WIDTH  (VALUE_BITS),
    .ADDR_W (TREE_D)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (val_wr_addr),
    .wr_data (val_wr_data),
    .rd_en   (val_rd_en),
    .rd_addr (val_rd_addr),
    .rd_data (val_rd_data)
  );

  assign in_stall = !walker_ready;

  // Output register. It frees the walker as soon as a result is handed over, so the
  // next request can be taken while the downstream side still stalls.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_chosen_index = out_res_r.chosen_index;
  assign out_chosen_value = out_res_r.chosen_value;
  assign out_total_weight = out_res_r.total_weight;

endmodule

`default_nettype wire

/* sim/tb_weighted_sum_tree_sampler.sv */
// Mirror of the sampler's sum tree. It tracks the node sums and leaf values as the
// block sees them, works out the result of every accepted request, and checks the
// results that come back in order.
class sum_tree_mirror;
  logic [wst_pkg::TOTAL_W-1:0] node_sum [2*wst_pkg::LEAVES_DEF-1];
  logic [wst_pkg::VALUE_W-1:0] leaf_value [wst_pkg::LEAVES_DEF];
  wst_pkg::wst_result_t owed_results[$];
  int unsigned errors;

  function new();
    foreach (node_sum[i]) node_sum[i] = '0;
    foreach (leaf_value[i]) leaf_value[i] = '0;
    errors = 0;
  endfunction

  function logic [wst_pkg::TOTAL_W-1:0] root_total();
    return node_sum[0];
  endfunction

  function int unsigned outstanding();
    return owed_results.size();
  endfunction

  function void note_request(input logic [wst_pkg::OP_W-1:0] op,
                             input logic [wst_pkg::IDX_W-1:0] idx,
                             input logic [wst_pkg::WEIGHT_W-1:0] weight,
                             input logic [wst_pkg::VALUE_W-1:0] value,
                             input logic [wst_pkg::ROLL_W-1:0] roll);
    wst_pkg::wst_result_t res;
    int depth;
    int first_leaf;
    int node;
    int lvl;
    logic [wst_pkg::TOTAL_W-1:0] rest;
    depth = $clog2(wst_pkg::LEAVES_DEF);
    first_leaf = (1 << depth) - 1;
    res = '0;
    res.total_weight = node_sum[0];
    if (op == wst_pkg::OP_WRITE) begin
      node = first_leaf + int'(idx);
      leaf_value[idx] = value;
      node_sum[node] = wst_pkg::TOTAL_W'(weight);
      for (lvl = 0; lvl < depth; lvl++) begin
        node = (node - 1) / 2;
        node_sum[node] = node_sum[2*node+1] + node_sum[2*node+2];
      end
      res.status = wst_pkg::ST_WRITTEN;
      res.total_weight = node_sum[0];
    end else if (node_sum[0] == 0 || wst_pkg::TOTAL_W'(roll) >= node_sum[0]) begin
      res.status = wst_pkg::ST_REFUSED;
    end else begin
      node = 0;
      rest = roll;
      for (lvl = 0; lvl < depth; lvl++) begin
        if (rest < node_sum[2*node+1]) begin
          node = 2*node + 1;
        end else begin
          rest = rest - node_sum[2*node+1];
          node = 2*node + 2;
        end
      end
      res.status = wst_pkg::ST_DRAWN;
      res.chosen_index = wst_pkg::IDX_W'(node - first_leaf);
      res.chosen_value = leaf_value[node - first_leaf];
    end
    owed_results = {owed_results, res};
  endfunction

  function void compare_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_result(input wst_pkg::wst_result_t got);
    wst_pkg::wst_result_t want;
    if (owed_results.size() == 0) begin
      $display({"%0t: result with nothing pending, expected none, ",
                "actual status %0d index %0d value %0d total %0d"},
               $time, got.status, got.chosen_index, got.chosen_value, got.total_weight);
      errors++;
      return;
    end
    want = owed_results.pop_front();
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("chosen_index", 32'(want.chosen_index), 32'(got.chosen_index));
    compare_field("chosen_value", 32'(want.chosen_value), 32'(got.chosen_value));
    compare_field("total_weight", 32'(want.total_weight), 32'(got.total_weight));
  endfunction
endclass

module tb_weighted_sum_tree_sampler;
  import wst_pkg::*;

  // The run is ended if this many cycles pass with no request and no result
  // accepted. The clearing pass after reset and the slowest legal request
  // (sender gap, walk, longest receiver stall) stay well below it.
  localparam int QUIET_LIMIT  = 2000;
  // Cycles to watch for stray results once nothing is pending any more.
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 700;
  localparam int LEAF_LAST     = LEAVES_DEF - 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
  localparam logic [ROLL_W-1:0]   ROLL_MAX   = '1;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation;
  logic [IDX_W-1:0]    in_leaf_index;
  logic [WEIGHT_W-1:0] in_item_weight;
  logic [VALUE_W-1:0]  in_item_value;
  logic [ROLL_W-1:0]   in_roll;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_W-1:0]    out_chosen_index;
  logic [VALUE_W-1:0]  out_chosen_value;
  logic [TOTAL_W-1:0]  out_total_weight;

  sum_tree_mirror mirror = new();

  int burst_left;
  int items_sent;
  int quiet_cycles;

  weighted_sum_tree_sampler u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_leaf_index    (in_leaf_index),
    .in_item_weight   (in_item_weight),
    .in_item_value    (in_item_value),
    .in_roll          (in_roll),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_chosen_index (out_chosen_index),
    .out_chosen_value (out_chosen_value),
    .out_total_weight (out_total_weight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure. The pattern switches every so often between no
  // stalls at all, light and heavy random stalls, and long stall runs, so that
  // stalls land on every stage of the walk and on back-to-back results.
  int  stall_mode;
  int  mode_left;
  int  run_left;
  bit  run_high;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: begin
        if (run_left == 0) begin
          run_high = ~run_high;
          run_left = run_high ? $urandom_range(1, 10) : $urandom_range(1, 4);
        end
        run_left--;
        out_stall <= run_high;
      end
    endcase
  end

  // Both channels are sampled at the rising edge. A request is handed to the
  // mirror the moment it is taken, a result is checked the moment it is taken,
  // and the quiet-cycle watchdog runs off the same two handshakes.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      mirror.note_request(in_operation, in_leaf_index, in_item_weight, in_item_value,
                          in_roll);
    end
    if (rst_n && out_valid && !out_stall) begin
      mirror.check_result({out_status, out_chosen_index, out_chosen_value,
                           out_total_weight});
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Presents one request and returns at the falling edge after it is taken.
  // The sender works in bursts; between bursts valid drops for a random gap.
  // Valid is left high on return so that the next request of a burst follows
  // without a bubble.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [WEIGHT_W-1:0] weight,
                              input logic [VALUE_W-1:0] value,
                              input logic [ROLL_W-1:0] roll);
    int gap;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid       = 1'b1;
    in_operation   = op;
    in_leaf_index  = idx;
    in_item_weight = weight;
    in_item_value  = value;
    in_roll        = roll;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Unused fields of a request carry random bits so that they toggle too.
  task automatic send_write(input logic [IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] weight,
                            input logic [VALUE_W-1:0] value);
    send_request(OP_WRITE, idx, weight, value, ROLL_W'($urandom));
  endtask

  task automatic send_draw(input logic [ROLL_W-1:0] roll);
    send_request(OP_DRAW, IDX_W'($urandom), WEIGHT_W'($urandom), VALUE_W'($urandom), roll);
  endtask

  // Holds the sender off until every pending result has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (mirror.outstanding() != 0) @(negedge clk);
  endtask

  // Weights lean toward zero, one, the maximum and small values, which shape
  // the tree the most, with plenty of fully random ones.
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WEIGHT_MAX;
      2:       return WEIGHT_W'(1);
      3, 4, 5: return WEIGHT_W'($urandom_range(1, 255));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // Most rolls fall inside 0..total-1 so the walk runs; some sit on the edges
  // of that range and some are out of range and must be refused.
  function automatic logic [ROLL_W-1:0] pick_roll();
    logic [TOTAL_W-1:0] total;
    total = mirror.root_total();
    if (total == 0 || $urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0:       return ROLL_W'(total);
        1:       return ROLL_MAX;
        default: return ROLL_W'($urandom);
      endcase
    end
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ROLL_W'(total - 1);
      default: return ROLL_W'($urandom_range(0, int'(total) - 1));
    endcase
  endfunction

  // Random mix of writes and draws on whatever the tree currently holds.
  task automatic run_mixed(input int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 4) begin
        send_write(IDX_W'($urandom_range(0, LEAF_LAST)), pick_weight(), VALUE_W'($urandom));
      end else begin
        send_draw(pick_roll());
      end
    end
  endtask

  // Every leaf at the largest weight, which gives the largest total the tree
  // can hold, then draws across it including the very last unit.
  task automatic run_fill();
    int start;
    start = $urandom_range(0, LEAF_LAST);
    for (int i = 0; i < LEAVES_DEF; i++) begin
      send_write(IDX_W'((start + i) % LEAVES_DEF), WEIGHT_MAX, VALUE_W'($urandom));
    end
    send_draw(ROLL_W'(mirror.root_total() - 1));
    send_draw(ROLL_MAX);
    repeat (12) send_draw(pick_roll());
  endtask

  // Nearly every leaf at zero weight, so the walk must step past long empty
  // subtrees. Sometimes no leaf is left and every draw is refused.
  task automatic run_sparse();
    for (int i = 0; i < LEAVES_DEF; i++) begin
      send_write(IDX_W'(i),
                 ($urandom_range(0, 20) == 0) ? WEIGHT_W'($urandom_range(1, 65535))
                                               : WEIGHT_W'(0),
                 VALUE_W'($urandom));
    end
    repeat (16) send_draw(pick_roll());
  endtask

  int directed_count;

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_WRITE;
    in_leaf_index  = '0;
    in_item_weight = '0;
    in_item_value  = '0;
    in_roll        = '0;
    burst_left     = 0;
    items_sent     = 0;
    quiet_cycles   = 0;
    stall_mode     = 0;
    mode_left      = 0;
    run_left       = 0;
    run_high       = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Draws on the empty tree are refused, whatever the roll.
    send_draw('0);
    send_draw(ROLL_MAX);

    // Four leaves with extreme and alternating bit patterns.
    send_write(IDX_W'(0), WEIGHT_MAX, VALUE_W'(16'hFFFF));
    send_write(IDX_W'(LEAF_LAST), WEIGHT_W'(1), VALUE_W'(0));
    send_write(IDX_W'(21), WEIGHT_W'(16'h5555), VALUE_W'(16'hAAAA));
    send_write(IDX_W'(42), WEIGHT_W'(16'hAAAA), VALUE_W'(16'h5555));

    // Boundaries of the first leaf, the start of the next, the last unit,
    // and rolls at and far beyond the total.
    send_draw('0);
    send_draw(ROLL_W'(16'hFFFE));
    send_draw(ROLL_W'(16'hFFFF));
    send_draw(ROLL_W'(mirror.root_total() - 1));
    send_draw(ROLL_W'(mirror.root_total()));
    send_draw(ROLL_MAX);

    // Leaves set back to zero weight can no longer be chosen.
    send_write(IDX_W'(LEAF_LAST), '0, VALUE_W'(16'h0F0F));
    send_draw(ROLL_W'(mirror.root_total() - 1));
    send_write(IDX_W'(0), '0, VALUE_W'(16'h1234));
    send_draw('0);

    // Rewriting a leaf with the same weight changes only its value.
    send_write(IDX_W'(21), WEIGHT_W'(16'h5555), VALUE_W'(16'hBEEF));
    send_draw(ROLL_W'(16'h5554));
    send_draw(ROLL_W'(16'h5555));

    // Let the block empty out completely before the random part.
    drain_results();
    directed_count = items_sent;

    // The largest total and a mostly empty tree are visited at least once,
    // then phases are picked at random, sometimes with a full drain between.
    run_fill();
    drain_results();
    run_sparse();
    while (items_sent < directed_count + RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       run_fill();
        1:       run_sparse();
        default: run_mixed($urandom_range(20, 80));
      endcase
      if ($urandom_range(0, 2) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mirror.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
